### rtl/xsci_pkg.sv
// Shared types, constants and helpers for the XML structural character indexer.
// No dependencies; imported by xsci_ctrl, xsci_datapath and the top level.
package xsci_pkg;

    localparam int BYTES_PER_WORD = 8;
    localparam int BYTE_W         = 8;
    localparam int WORD_W         = BYTES_PER_WORD * BYTE_W;
    localparam int NVALID_W       = 4;
    localparam int IDX_W          = 3;
    localparam int OFFSET_W       = 31;
    localparam int COUNT_W        = 16;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
    localparam logic [COUNT_W-1:0]  INDEX_LIMIT_RESET = 16'd1024;

    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_DONE     = 1'b1;

    localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C; // <
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E; // >
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F; // /
    localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D; // =
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22; // "
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27; // '
    localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26; // &

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } xsci_state_t;

    typedef struct packed {
        logic load;       // take a new input word
        logic emit_pos;   // load a position result into the output register
        logic emit_done;  // load the end-of-buffer result
    } xsci_cmd_t;

    typedef struct packed {
        logic has_pos;    // a match remains and the limit allows it
        logic more_pos;   // another position follows the current one
        logic last_word;  // the word held closes its buffer
        logic out_free;   // output register can take a result this cycle
    } xsci_status_t;

    function automatic logic is_structural(input logic [BYTE_W-1:0] b);
        return (b == CH_LT) || (b == CH_GT) || (b == CH_SLASH) || (b == CH_EQ) ||
               (b == CH_DQUOTE) || (b == CH_SQUOTE) || (b == CH_AMP);
    endfunction

endpackage

### rtl/xsci_ctrl.sv
// Controller state machine of the XML structural character indexer.
// Depends on xsci_pkg; drives commands to xsci_datapath from its status.
module xsci_ctrl
    import xsci_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  xsci_status_t status,
    output xsci_cmd_t    cmd
);

    xsci_state_t state_reg;
    xsci_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.has_pos)
                begin
                    // hold until the output register frees up
                    if (status.out_free)
                    begin
                        cmd.emit_pos = 1'b1;
                        if (!status.more_pos)
                            state_next = status.last_word ? ST_DONE : ST_IDLE;
                    end
                end
                else
                begin
                    state_next = status.last_word ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/xsci_datapath.sv
// Datapath of the XML structural character indexer: byte classifier, match mask,
// offset and count registers, limit register and output register. Uses xsci_pkg.
module xsci_datapath
    import xsci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  xsci_cmd_t             cmd,
    output xsci_status_t          status,
    input  logic                  cfg_wr_en,
    input  logic [COUNT_W-1:0]    cfg_wr_data,
    input  logic [WORD_W-1:0]     data_word,
    input  logic [NVALID_W-1:0]   valid_bytes,
    input  logic                  first_of_buffer,
    input  logic                  last_of_buffer,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [OFFSET_W-1:0]   position,
    output logic [COUNT_W-1:0]    total_count,
    output logic                  last
);

    logic [BYTES_PER_WORD-1:0] mask_reg;
    logic [OFFSET_W-1:0]       base_reg;
    logic [OFFSET_W-1:0]       offset_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        max_reg;
    logic                      last_word_reg;
    logic                      out_valid_reg;
    logic                      kind_reg;
    logic [OFFSET_W-1:0]       position_reg;
    logic [COUNT_W-1:0]        total_reg;
    logic                      last_reg;

    logic [NVALID_W-1:0]       nvalid;
    logic [BYTES_PER_WORD-1:0] mask_in;
    logic [OFFSET_W-1:0]       base_in;
    logic [OFFSET_W:0]         offset_sum;
    logic [OFFSET_W-1:0]       offset_next;
    logic [BYTES_PER_WORD-1:0] mask_rest;
    logic [IDX_W-1:0]          hit_idx;
    logic [OFFSET_W:0]         pos_sum;
    logic [OFFSET_W-1:0]       pos_sat;
    logic [COUNT_W:0]          count_inc;

    // classify the incoming word
    always_comb
    begin
        nvalid = (valid_bytes > NVALID_W'(BYTES_PER_WORD)) ?
                 NVALID_W'(BYTES_PER_WORD) : valid_bytes;
        for (int i = 0; i < BYTES_PER_WORD; i++)
            mask_in[i] = (NVALID_W'(i) < nvalid) &&
                         is_structural(data_word[i*BYTE_W +: BYTE_W]);
        base_in     = first_of_buffer ? '0 : offset_reg;
        offset_sum  = {1'b0, base_in} + (OFFSET_W+1)'(nvalid);
        offset_next = offset_sum[OFFSET_W] ? OFFSET_MAX : offset_sum[OFFSET_W-1:0];
    end

    // lowest pending match
    always_comb
    begin
        hit_idx = '0;
        for (int i = BYTES_PER_WORD - 1; i >= 0; i--)
            if (mask_reg[i])
                hit_idx = IDX_W'(i);
        mask_rest = mask_reg & (mask_reg - BYTES_PER_WORD'(1));
        pos_sum   = {1'b0, base_reg} + (OFFSET_W+1)'(hit_idx);
        pos_sat   = pos_sum[OFFSET_W] ? OFFSET_MAX : pos_sum[OFFSET_W-1:0];
        count_inc = {1'b0, count_reg} + (COUNT_W+1)'(1);
    end

    assign status.has_pos   = (mask_reg != '0) && (count_reg < max_reg);
    assign status.more_pos  = (mask_rest != '0) && (count_inc < {1'b0, max_reg});
    assign status.last_word = last_word_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            count_reg  <= '0;
            max_reg    <= INDEX_LIMIT_RESET;
            mask_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                max_reg <= cfg_wr_data;
            if (cmd.load)
            begin
                offset_reg <= offset_next;
                mask_reg   <= mask_in;
                if (first_of_buffer)
                    count_reg <= '0;
            end
            else if (cmd.emit_pos)
            begin
                mask_reg  <= mask_rest;
                count_reg <= count_inc[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg      <= base_in;
            last_word_reg <= last_of_buffer;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_pos || cmd.emit_done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_pos)
        begin
            kind_reg     <= KIND_POSITION;
            position_reg <= pos_sat;
            total_reg    <= count_inc[COUNT_W-1:0];
            last_reg     <= !last_word_reg && !status.more_pos;
        end
        else if (cmd.emit_done)
        begin
            kind_reg     <= KIND_DONE;
            position_reg <= '0;
            total_reg    <= count_reg;
            last_reg     <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign position    = position_reg;
    assign total_count = total_reg;
    assign last        = last_reg;

endmodule

### rtl/xml_structural_char_indexer.sv
// Top level of the XML structural character indexer.
// Depends on xsci_pkg, xsci_ctrl and xsci_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one 8-byte word per transaction
//   with data_word, valid_bytes, first_of_buffer and last_of_buffer. Output
//   channel (out_valid / out_stall) carries one result per transaction: a
//   position result (kind 0) for each structural byte < > / = " ' & up to the
//   index limit, in ascending byte order, then a done result (kind 1) after the
//   last word of a buffer. last marks the final result caused by a word.
//   cfg_wr_en / cfg_wr_data write the index limit; write it only while idle.
// Timing:
//   A word is accepted from idle; the sequencer then emits its positions one
//   at a time (it still visits the scan state when none are emitted) and then
//   the done result if last_of_buffer is set. It emits one result per cycle
//   through a single output register while that register is free. While
//   out_stall is high and the output register is full, a sequencer with a
//   result to emit holds and in_stall stays high. A finished result may wait
//   in the output register while the next word is accepted.
// Reset:
//   Clears offset and count, sets the index limit to 1024, empties the output.
module xml_structural_char_indexer
    import xsci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [COUNT_W-1:0]    cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [WORD_W-1:0]     data_word,
    input  logic [NVALID_W-1:0]   valid_bytes,
    input  logic                  first_of_buffer,
    input  logic                  last_of_buffer,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [OFFSET_W-1:0]   position,
    output logic [COUNT_W-1:0]    total_count,
    output logic                  last
);

    xsci_cmd_t    cmd;
    xsci_status_t status;

    // sequencer: accept a word, step through its matches, append the done result
    xsci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // classifier, offset/count state and output register
    xsci_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .data_word       (data_word),
        .valid_bytes     (valid_bytes),
        .first_of_buffer (first_of_buffer),
        .last_of_buffer  (last_of_buffer),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .position        (position),
        .total_count     (total_count),
        .last            (last)
    );

endmodule

### tb/xml_structural_char_indexer_tb.sv
// Self-checking testbench for xml_structural_char_indexer: a directed table,
// then random buffers; results are checked by an in-bench model or typed row.
// Depends on xsci_pkg and the RTL of the indexer; nothing else.
module xml_structural_char_indexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xsci_pkg::*;

    localparam realtime CLK_HALF        = 5.0ns;
    localparam int      RESET_CYCLES    = 11;
    // A word with no result still keeps the block busy in its scan state;
    // drain past that before touching the register.
    localparam int      DRAIN_CYCLES    = 8;
    localparam int      WATCHDOG_LIMIT  = 1000;
    localparam int      LONG_HOLD       = 64;
    localparam int      RAND_PHASES     = 4;
    localparam int      WORDS_PER_PHASE = 60;
    localparam int      CALM_WORDS      = 40;

    // One input word as the block sees it.
    typedef struct packed {
        logic [WORD_W-1:0]   data;
        logic [NVALID_W-1:0] nvalid;
        logic                first;
        logic                lastw;
    } word_t;

    // One result transaction.
    typedef struct packed {
        logic                kind;
        logic [OFFSET_W-1:0] pos;
        logic [COUNT_W-1:0]  total;
        logic                last;
    } mark_t;

    // A directed row is either a register write or a word; a word row may
    // carry its single result typed in by hand.
    typedef struct {
        bit                 is_cfg;
        logic [COUNT_W-1:0] cfg_value;
        word_t              w;
        bit                 typed;
        mark_t              res;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [COUNT_W-1:0]  cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [WORD_W-1:0]   data_word;
    logic [NVALID_W-1:0] valid_bytes;
    logic                first_of_buffer;
    logic                last_of_buffer;
    logic                out_valid;
    logic                out_stall;
    logic                kind;
    logic [OFFSET_W-1:0] position;
    logic [COUNT_W-1:0]  total_count;
    logic                last;

    // Model state: offset of byte zero of the next word, positions emitted
    // for the current buffer, and the shadow of the index limit.
    logic [OFFSET_W-1:0] buf_offset  = '0;
    logic [COUNT_W-1:0]  pos_count   = '0;
    logic [COUNT_W-1:0]  index_limit = INDEX_LIMIT_RESET;

    mark_t due_marks[$];   // results owed by the block, oldest first
    int    fails        = 0;
    int    random_words = 0;
    int    idle_cycles  = 0;
    bit    calm_tail    = 1'b0;

    xml_structural_char_indexer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_word       (data_word),
        .valid_bytes     (valid_bytes),
        .first_of_buffer (first_of_buffer),
        .last_of_buffer  (last_of_buffer),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .position        (position),
        .total_count     (total_count),
        .last            (last)
    );

    always #CLK_HALF clk = ~clk;

    // Saturating offset arithmetic: the offset sticks at its top value.
    function automatic logic [OFFSET_W-1:0] offset_plus(input logic [OFFSET_W-1:0] base,
                                                        input int unsigned step);
        logic [63:0] sum;
        sum = 64'(base) + 64'(step);
        return (sum > 64'(OFFSET_MAX)) ? OFFSET_MAX : sum[OFFSET_W-1:0];
    endfunction

    // Classify one accepted word and advance the model state; the results it
    // causes land in batch, the final one flagged last.
    function automatic void classify_word(input word_t w, ref mark_t batch[$]);
        logic [NVALID_W-1:0] span;
        logic [7:0]          b;
        mark_t               r;
        batch.delete();
        if (w.first)
        begin
            buf_offset = '0;
            pos_count  = '0;
        end
        // clamp an oversized valid count to a full word
        span = (w.nvalid > BYTES_PER_WORD) ? NVALID_W'(BYTES_PER_WORD) : w.nvalid;
        for (int i = 0; i < span; i++)
        begin
            b = w.data[8*i +: 8];
            if ((b == CH_LT || b == CH_GT || b == CH_SLASH || b == CH_EQ ||
                 b == CH_DQUOTE || b == CH_SQUOTE || b == CH_AMP) &&
                pos_count < index_limit)
            begin
                pos_count++;
                r = '{KIND_POSITION, offset_plus(buf_offset, i), pos_count, 1'b0};
                batch.push_back(r);
            end
        end
        buf_offset = offset_plus(buf_offset, span);
        if (w.lastw)
        begin
            r = '{KIND_DONE, '0, pos_count, 1'b0};
            batch.push_back(r);
        end
        if (batch.size() != 0)
            batch[batch.size()-1].last = 1'b1;
    endfunction

    // Byte content with about half the bytes structural, now and then a
    // fully random word so that every data bit toggles.
    function automatic logic [WORD_W-1:0] markup_rich_word();
        logic [WORD_W-1:0] d;
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom};
        for (int k = 0; k < BYTES_PER_WORD; k++)
        begin
            case ($urandom_range(0, 13))
                0:       d[8*k +: 8] = CH_LT;
                1:       d[8*k +: 8] = CH_GT;
                2:       d[8*k +: 8] = CH_SLASH;
                3:       d[8*k +: 8] = CH_EQ;
                4:       d[8*k +: 8] = CH_DQUOTE;
                5:       d[8*k +: 8] = CH_SQUOTE;
                6:       d[8*k +: 8] = CH_AMP;
                default: d[8*k +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return d;
    endfunction

    function automatic plan_row_t word_row(input logic [WORD_W-1:0] data,
                                           input int nv, input bit f, input bit l);
        plan_row_t row;
        row.is_cfg    = 1'b0;
        row.cfg_value = '0;
        row.w         = '{data, NVALID_W'(nv), f, l};
        row.typed     = 1'b0;
        row.res       = '0;
        return row;
    endfunction

    // Word whose only result is known by inspection.
    function automatic plan_row_t typed_row(input logic [WORD_W-1:0] data,
                                            input int nv, input bit f, input bit l,
                                            input logic k, input int total);
        plan_row_t row;
        row       = word_row(data, nv, f, l);
        row.typed = 1'b1;
        row.res   = '{k, '0, COUNT_W'(total), 1'b1};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input int value);
        plan_row_t row;
        row           = word_row('0, 0, 1'b0, 1'b0);
        row.is_cfg    = 1'b1;
        row.cfg_value = COUNT_W'(value);
        return row;
    endfunction

    // Offer one word, hold it until accepted, then book its results. A random
    // gap with valid low may precede it; valid never looks at stall.
    task automatic push_word(input word_t w, input bit typed, input mark_t typed_res);
        mark_t batch[$];
        int    gap;
        if (!calm_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        data_word       <= w.data;
        valid_bytes     <= w.nvalid;
        first_of_buffer <= w.first;
        last_of_buffer  <= w.lastw;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        classify_word(w, batch);
        if (typed)
            due_marks.push_back(typed_res);
        else
            foreach (batch[k]) due_marks.push_back(batch[k]);
    endtask

    // Drop valid and wait for the block to drain, including its work on words
    // that owe nothing.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_marks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the index limit only once the block is idle.
    task automatic write_limit(input logic [COUNT_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        index_limit = value;
    endtask

    // Output pacing: short random stalls, one long hold-off early in the
    // random part so the block backs up into its input, and none at the end.
    initial
    begin : rx_pacing
        int burst;
        bit long_hold_done;
        burst          = 0;
        long_hold_done = 1'b0;
        out_stall      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && random_words >= 30)
            begin
                long_hold_done = 1'b1;
                burst          = LONG_HOLD;
            end
            else if (burst == 0 && !calm_tail && $urandom_range(0, 4) == 0)
                burst = $urandom_range(1, 4);
            if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Check every result transaction against the oldest one owed.
    always @(posedge clk)
    begin
        mark_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (due_marks.size() == 0)
            begin
                $error("result with none owed: kind %0d position %0d total_count %0d",
                       kind, position, total_count);
                fails++;
            end
            else
            begin
                want = due_marks.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    fails++;
                end
                if (position !== want.pos)
                begin
                    $error("position: expected %0d, got %0d", want.pos, position);
                    fails++;
                end
                if (total_count !== want.total)
                begin
                    $error("total_count: expected %0d, got %0d", want.total, total_count);
                    fails++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    fails++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("xml_structural_char_indexer_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t          plan[$];
        word_t              w;
        int                 nwords;
        int                 phase_words;
        logic [COUNT_W-1:0] limit_pick;

        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        data_word       = '0;
        valid_bytes     = '0;
        first_of_buffer = 1'b0;
        last_of_buffer  = 1'b0;

        // Directed table, limit at its reset value of 1024 to begin with.
        // First structural byte after reset lands at offset zero.
        plan.push_back(typed_row(64'h0000_0000_0000_003C, 1, 1, 0, KIND_POSITION, 1));
        // all seven characters plus a letter
        plan.push_back(word_row(64'h3C41_2627_223D_2F3E, 8, 0, 0));
        // neighbours of the structural codes: nothing matches
        plan.push_back(word_row(64'h2825_2321_302E_3F3B, 8, 0, 0));
        // zero valid bytes on a last word: done only, offset held
        plan.push_back(typed_row(64'h3C3C_3C3C_3C3C_3C3C, 0, 0, 1, KIND_DONE, 8));
        // no first flag after a last word, and an oversized valid count
        plan.push_back(word_row(64'h3C3C_3C3C_3C3C_3C3C, 15, 0, 0));
        plan.push_back(typed_row(64'hFFFF_FFFF_FFFF_FFFF, 9, 1, 1, KIND_DONE, 0));
        plan.push_back(word_row(64'h0000_0000_0000_0000, 0, 1, 0));
        // matches beyond the valid bytes are ignored
        plan.push_back(word_row(64'h3C3C_3C3C_3C26_2722, 3, 1, 1));
        // a zero limit emits no positions
        plan.push_back(cfg_row(0));
        plan.push_back(typed_row(64'h3C3C_3C3C_3C3C_3C3C, 8, 1, 1, KIND_DONE, 0));
        // limit reached inside a buffer, later matches dropped
        plan.push_back(cfg_row(3));
        plan.push_back(word_row(64'h2626_2626_2626_2626, 8, 1, 0));
        plan.push_back(typed_row(64'h2F2F_2F2F_2F2F_2F2F, 8, 0, 1, KIND_DONE, 3));
        // limit lowered below the count mid-buffer
        plan.push_back(cfg_row(65535));
        plan.push_back(word_row(64'h3D3D_3D3D_3D3D_3D3D, 8, 1, 0));
        plan.push_back(cfg_row(5));
        plan.push_back(typed_row(64'h2222_2222_2222_2222, 8, 0, 1, KIND_DONE, 8));
        plan.push_back(cfg_row(1));
        plan.push_back(word_row(64'h2727_2727_2727_2727, 4, 1, 1));
        plan.push_back(cfg_row(INDEX_LIMIT_RESET));
        plan.push_back(word_row(64'h3E00_0000_0000_0000, 7, 1, 0));
        plan.push_back(word_row(64'h2641_4141_4141_4126, 8, 0, 1));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].is_cfg)
                write_limit(plan[r].cfg_value);
            else
                push_word(plan[r].w, plan[r].typed, plan[r].res);
        end

        // Random part: mostly well-formed buffers of 1 to 6 words, the rest
        // noise words with arbitrary flags and valid counts. Each phase runs
        // under its own limit.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       limit_pick = COUNT_W'($urandom_range(1, 12));
                1:       limit_pick = 16'hFFFF;
                2:       limit_pick = COUNT_W'($urandom_range(0, 65535));
                default: limit_pick = INDEX_LIMIT_RESET;
            endcase
            write_limit(limit_pick);
            phase_words = 0;
            while (phase_words < WORDS_PER_PHASE)
            begin
                nwords = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(1, 6);
                for (int k = 0; k < nwords; k++)
                begin
                    w.data = markup_rich_word();
                    if (nwords == 1 && $urandom_range(0, 1) == 0)
                    begin
                        // noise: anything the fields allow
                        w.nvalid = NVALID_W'($urandom_range(0, 15));
                        w.first  = 1'($urandom_range(0, 1));
                        w.lastw  = 1'($urandom_range(0, 1));
                    end
                    else
                    begin
                        w.first = (k == 0);
                        w.lastw = (k == nwords - 1);
                        if (w.lastw)
                            w.nvalid = NVALID_W'($urandom_range(1, 8));
                        else if ($urandom_range(0, 3) == 0)
                            w.nvalid = NVALID_W'($urandom_range(0, 15));
                        else
                            w.nvalid = NVALID_W'(BYTES_PER_WORD);
                    end
                    // stop all idling for the closing stretch
                    if (ph == RAND_PHASES - 1 && phase_words >= WORDS_PER_PHASE - CALM_WORDS)
                        calm_tail = 1'b1;
                    push_word(w, 1'b0, '0);
                    phase_words++;
                    random_words++;
                end
            end
        end

        settle();
        if (fails == 0)
            $display("xml_structural_char_indexer_tb OK");
        else
            $display("xml_structural_char_indexer_tb NOT OK");
        $finish;
    end

endmodule
